@@ rtl/core/ttmm_pkg.sv @@
// Shared constants, types and command codes for the min/max winner tree.
package ttmm_pkg;

    // Fixed field widths of the request and response channels
    localparam int CMD_BITS   = 2;
    localparam int POS_BITS   = 8;
    localparam int FIELD_BITS = 32;

    // Defaults for the top-level parameters
    localparam int SLOT_COUNT_DEF = 128;
    localparam int VALUE_BITS_DEF = 32;

    typedef logic [CMD_BITS-1:0]          t_cmd;
    typedef logic [POS_BITS-1:0]          t_pos;
    typedef logic signed [FIELD_BITS-1:0] t_field;

    // Request commands; the unused code behaves as a read
    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_READ  = 2'd1;
    localparam t_cmd CMD_EMPTY = 2'd2;

endpackage

@@ rtl/core/ttmm_chan_if.sv @@
// Request and response channel interfaces of the min/max winner tree.
interface ttmm_req_if;
    logic                  valid;
    logic                  ready;
    ttmm_pkg::t_cmd        command;
    ttmm_pkg::t_pos        position;
    ttmm_pkg::t_field      value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface ttmm_rsp_if;
    logic                  valid;
    logic                  ready;
    ttmm_pkg::t_field      min_value;
    ttmm_pkg::t_pos        min_position;
    ttmm_pkg::t_field      max_value;
    ttmm_pkg::t_pos        max_position;
    logic                  any_occupied;
    ttmm_pkg::t_field      slot_value;
    logic                  slot_occupied;

    modport source (output valid, min_value, min_position, max_value, max_position,
                    any_occupied, slot_value, slot_occupied, input ready);
    modport sink   (input valid, min_value, min_position, max_value, max_position,
                    any_occupied, slot_value, slot_occupied, output ready);
endinterface

@@ rtl/core/ttmm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module ttmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ttmm_merge.sv @@
// Parent node from the node just updated and its sibling; ties go left.
module ttmm_merge #(
    parameter int VALUE_BITS = ttmm_pkg::VALUE_BITS_DEF
) (
    input  logic [2*VALUE_BITS+2*ttmm_pkg::POS_BITS-1:0] i_cur,
    input  logic [2*VALUE_BITS+2*ttmm_pkg::POS_BITS-1:0] i_sib,
    input  logic                                         i_sib_occ,
    input  logic                                         i_cur_right,
    output logic [2*VALUE_BITS+2*ttmm_pkg::POS_BITS-1:0] o_parent
);

    localparam int PB       = ttmm_pkg::POS_BITS;
    localparam int REC_BITS = 2*VALUE_BITS + 2*PB;

    // Record layout: {min key, max key, min slot, max slot}
    logic [REC_BITS-1:0]   lft;
    logic [REC_BITS-1:0]   rgt;
    logic [VALUE_BITS-1:0] l_min, r_min, l_max, r_max;
    logic                  min_from_l;
    logic                  max_from_l;

    assign lft   = i_cur_right ? i_sib : i_cur;
    assign rgt   = i_cur_right ? i_cur : i_sib;
    assign l_min = lft[REC_BITS-1 -: VALUE_BITS];
    assign r_min = rgt[REC_BITS-1 -: VALUE_BITS];
    assign l_max = lft[2*PB +: VALUE_BITS];
    assign r_max = rgt[2*PB +: VALUE_BITS];

    // Keys are sign-flipped, so unsigned compares order them
    assign min_from_l = (l_min <= r_min);
    assign max_from_l = (l_max >= r_max);

    always_comb begin
        if (!i_sib_occ) begin
            o_parent = i_cur;
        end else begin
            o_parent = {min_from_l ? l_min : r_min,
                        max_from_l ? l_max : r_max,
                        min_from_l ? lft[PB +: PB] : rgt[PB +: PB],
                        max_from_l ? lft[0 +: PB] : rgt[0 +: PB]};
        end
    end

endmodule

@@ rtl/core/tournament_tree_min_max.sv @@
// Winner tree tracking min and max (with lowest slot) over numbered slots; node records
// live in one dual-port RAM. A write stores the leaf, then climbs one tree level per
// cycle: each cycle merges the registered child with its sibling read from the RAM,
// writes the parent and reads the next sibling until it writes the root. A read goes through
// a lookup state and an empty-all goes straight to the finish state, one request at a time.
// The single RAM read port serves one sibling read per level of the climb. Occupancy bits
// sit in flip-flops that reset and empty-all clear at once, so no clearing pass is run.
// The response register lets a new request enter while the previous response waits.
module tournament_tree_min_max #(
    parameter int SLOT_COUNT = ttmm_pkg::SLOT_COUNT_DEF,
    parameter int VALUE_BITS = ttmm_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttmm_req_if.sink   i_req,
    ttmm_rsp_if.source o_rsp
);

    localparam int PB        = ttmm_pkg::POS_BITS;
    localparam int FB        = ttmm_pkg::FIELD_BITS;
    localparam int LEAF_BITS = $clog2(SLOT_COUNT);
    localparam int NODES     = 2 << LEAF_BITS;
    localparam int NB        = LEAF_BITS + 1;
    localparam int REC_BITS  = 2*VALUE_BITS + 2*PB;
    localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [NB-1:0]         ROOT = NB'(1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CLIMB  = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Key back to the response field, zero-filled or cut to the field width
    function automatic ttmm_pkg::t_field key_to_field(input logic [VALUE_BITS-1:0] k);
        logic [VALUE_BITS+FB-1:0] w;
        w = {{FB{1'b0}}, k ^ SIGN};
        return ttmm_pkg::t_field'(w[FB-1:0]);
    endfunction

    logic [1:0]            r_state;
    logic [NB-1:0]         r_node;
    logic [NB-1:0]         r_leaf;
    logic [REC_BITS-1:0]   r_cur;
    logic [REC_BITS-1:0]   r_root;
    logic [NODES-1:0]      r_occ;
    logic                  r_pos_ok;
    ttmm_pkg::t_field      r_slot_val;
    logic                  r_slot_occ;
    logic                  r_out_valid;
    ttmm_pkg::t_field      r_out_min;
    ttmm_pkg::t_pos        r_out_min_pos;
    ttmm_pkg::t_field      r_out_max;
    ttmm_pkg::t_pos        r_out_max_pos;
    logic                  r_out_any;
    ttmm_pkg::t_field      r_out_slot_val;
    logic                  r_out_slot_occ;

    logic                      req_fire;
    logic                      pos_ok;
    logic                      is_write;
    ttmm_pkg::t_pos            pos_m1;
    logic [LEAF_BITS+PB-1:0]   pos_ext;
    logic [NB-1:0]             leaf_idx;
    logic [VALUE_BITS+FB-1:0]  raw_ext;
    logic [VALUE_BITS-1:0]     key_in;
    logic [REC_BITS-1:0]       leaf_rec;
    logic [NB-1:0]             sib_idx;
    logic [NB-1:0]             p_idx;
    logic [NB-1:0]             p_sib;
    logic [REC_BITS-1:0]       m_rec;
    logic [REC_BITS-1:0]       rd_rec;
    logic                      load_out;
    logic                      lookup_hit;
    logic                      mem_we;
    logic                      mem_re;
    logic [NB-1:0]             mem_waddr;
    logic [NB-1:0]             mem_raddr;
    logic [REC_BITS-1:0]       mem_wdata;

    // Request decode
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && (r_state == ST_IDLE);
    assign pos_ok      = (i_req.position != '0) &&
                         (32'(i_req.position) <= 32'(SLOT_COUNT));
    assign is_write    = (i_req.command == ttmm_pkg::CMD_WRITE) && pos_ok;
    assign pos_m1      = i_req.position - PB'(1);
    assign pos_ext     = {{LEAF_BITS{1'b0}}, pos_m1};
    assign leaf_idx    = {1'b1, pos_ext[LEAF_BITS-1:0]};
    assign raw_ext     = {{VALUE_BITS{1'b0}}, i_req.value};
    assign key_in      = raw_ext[VALUE_BITS-1:0] ^ SIGN;
    assign leaf_rec    = {key_in, key_in, i_req.position, i_req.position};

    // Tree walk addressing
    assign sib_idx = {r_node[NB-1:1], ~r_node[0]};
    assign p_idx   = {1'b0, r_node[NB-1:1]};
    assign p_sib   = {p_idx[NB-1:1], ~p_idx[0]};

    ttmm_merge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_merge (
        .i_cur       (r_cur),
        .i_sib       (rd_rec),
        .i_sib_occ   (r_occ[sib_idx]),
        .i_cur_right (r_node[0]),
        .o_parent    (m_rec)
    );

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = leaf_idx;
        mem_wdata = leaf_rec;
        mem_re    = 1'b0;
        mem_raddr = leaf_idx;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    mem_re = 1'b1;
                    if (is_write) begin
                        mem_we    = 1'b1;
                        mem_raddr = {leaf_idx[NB-1:1], ~leaf_idx[0]};
                    end
                end
            end
            ST_CLIMB: begin
                mem_we    = 1'b1;
                mem_waddr = p_idx;
                mem_wdata = m_rec;
                mem_re    = (p_idx != ROOT);
                mem_raddr = p_sib;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    ttmm_ram #(
        .WIDTH (REC_BITS),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_rec)
    );

    assign load_out   = (r_state == ST_FINISH) && (!r_out_valid || o_rsp.ready);
    assign lookup_hit = r_pos_ok && r_occ[r_leaf];

    // Sequencer, occupancy and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (req_fire) begin
                        r_node   <= leaf_idx;
                        r_leaf   <= leaf_idx;
                        r_cur    <= leaf_rec;
                        r_pos_ok <= pos_ok;
                        if (is_write) begin
                            r_occ[leaf_idx] <= 1'b1;
                            r_slot_val      <= key_to_field(key_in);
                            r_slot_occ      <= 1'b1;
                            r_state         <= ST_CLIMB;
                        end else if (i_req.command == ttmm_pkg::CMD_EMPTY) begin
                            r_occ      <= '0;
                            r_slot_val <= '0;
                            r_slot_occ <= 1'b0;
                            r_state    <= ST_FINISH;
                        end else begin
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                ST_CLIMB: begin
                    r_occ[p_idx] <= 1'b1;
                    r_node       <= p_idx;
                    r_cur        <= m_rec;
                    if (p_idx == ROOT) begin
                        r_root  <= m_rec;
                        r_state <= ST_FINISH;
                    end
                end
                ST_LOOKUP: begin
                    r_slot_occ <= lookup_hit;
                    r_slot_val <= lookup_hit ?
                                  key_to_field(rd_rec[REC_BITS-1 -: VALUE_BITS]) : '0;
                    r_state    <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload, zero when the tree is empty
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_any      <= r_occ[ROOT];
            r_out_min      <= r_occ[ROOT] ?
                              key_to_field(r_root[REC_BITS-1 -: VALUE_BITS]) : '0;
            r_out_max      <= r_occ[ROOT] ? key_to_field(r_root[2*PB +: VALUE_BITS]) : '0;
            r_out_min_pos  <= r_occ[ROOT] ? r_root[PB +: PB] : '0;
            r_out_max_pos  <= r_occ[ROOT] ? r_root[0 +: PB] : '0;
            r_out_slot_val <= r_slot_val;
            r_out_slot_occ <= r_slot_occ;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.min_value     = r_out_min;
    assign o_rsp.min_position  = r_out_min_pos;
    assign o_rsp.max_value     = r_out_max;
    assign o_rsp.max_position  = r_out_max_pos;
    assign o_rsp.any_occupied  = r_out_any;
    assign o_rsp.slot_value    = r_out_slot_val;
    assign o_rsp.slot_occupied = r_out_slot_occ;

endmodule

@@ rtl/core/ttmm_checker.sv @@
// Port-level checks for the min/max winner tree, bound to the top level.
module ttmm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input ttmm_pkg::t_field i_min_value,
    input ttmm_pkg::t_pos   i_min_position,
    input ttmm_pkg::t_field i_max_value,
    input ttmm_pkg::t_pos   i_max_position,
    input logic             i_any_occupied,
    input ttmm_pkg::t_field i_slot_value,
    input logic             i_slot_occupied
);

    // A pending response stays until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped before it was taken");

    // One request in flight: ready falls after an accepted request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted while one is in progress");

    // An empty tree reports zeros
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_any_occupied |->
            i_min_value == '0 && i_max_value == '0 &&
            i_min_position == '0 && i_max_position == '0)
        else $error("empty tree reports nonzero extremes");

    // A non-empty tree names real slots, and one slot means one value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_any_occupied |->
            i_min_position != '0 && i_max_position != '0 &&
            (i_min_position != i_max_position || i_min_value == i_max_value))
        else $error("occupied tree reports inconsistent positions");

    // An empty slot reads zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_slot_occupied |-> i_slot_value == '0)
        else $error("empty slot reports a value");

endmodule

bind tournament_tree_min_max ttmm_checker u_ttmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_min_value     (o_rsp.min_value),
    .i_min_position  (o_rsp.min_position),
    .i_max_value     (o_rsp.max_value),
    .i_max_position  (o_rsp.max_position),
    .i_any_occupied  (o_rsp.any_occupied),
    .i_slot_value    (o_rsp.slot_value),
    .i_slot_occupied (o_rsp.slot_occupied)
);
